>>> sv/i2cbs_pkg.sv
// i2cbs_pkg: shared types and constants for the I2C master bit sequencer.
// No dependencies; used by i2cbs_core and i2c_master_bit_sequencer.
package i2cbs_pkg;

    localparam int unsigned CMD_W        = 3;
    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned BITCNT_W     = 4;
    localparam int unsigned S_TDATA_W    = 16;
    localparam int unsigned M_TDATA_W    = 16;
    localparam int unsigned APB_ADDR_W   = 3;
    localparam int unsigned APB_DATA_W   = 32;

    localparam logic [BYTE_W-1:0]        PHASE_TICKS_RST = 8'd2;
    localparam logic [APB_ADDR_W-1:0]    ADDR_PHASE_TICKS = 3'd0;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_WACK  = 3'd4,
        CMD_READ  = 3'd5,
        CMD_ACK   = 3'd6,
        CMD_NACK  = 3'd7
    } cmd_t;

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_START = 8'b0000_0010,
        ST_STOP  = 8'b0000_0100,
        ST_WACK  = 8'b0000_1000,
        ST_WRITE = 8'b0001_0000,
        ST_WREL  = 8'b0010_0000,
        ST_READ  = 8'b0100_0000,
        ST_ACK   = 8'b1000_0000
    } state_t;

    typedef struct packed {
        state_t                state;
        logic [BYTE_W-1:0]     phase_count;
        logic [BITCNT_W-1:0]   bit_count;
        logic [BYTE_W-1:0]     shift_byte;
        logic                  held_ack;
        logic                  scl;
        logic                  sda;
        logic                  nack;
        logic [BYTE_W-1:0]     read_data;
    } seq_t;

    localparam seq_t SEQ_RST = '{
        state:       ST_IDLE,
        phase_count: '0,
        bit_count:   '0,
        shift_byte:  '0,
        held_ack:    1'b0,
        scl:         1'b1,
        sda:         1'b1,
        nack:        1'b0,
        read_data:   '0
    };

endpackage

>>> sv/i2cbs_core.sv
// i2cbs_core: next-state logic of the bit sequencer for one tick.
// Depends on i2cbs_pkg (seq_t, state_t, cmd_t).
module i2cbs_core (
    input  i2cbs_pkg::seq_t           cur,
    input  logic [2:0]                command,
    input  logic [7:0]                write_data,
    input  logic                      ack_after_read,
    input  logic                      sda_in,
    input  logic [7:0]                phase_ticks,
    output i2cbs_pkg::seq_t           nxt,
    output logic                      done
);
    import i2cbs_pkg::*;

    logic [BYTE_W-1:0] plen;
    logic              fin;

    always_comb begin
        nxt  = cur;
        done = 1'b0;
        fin  = 1'b0;
        plen = (phase_ticks == '0) ? 8'd1 : phase_ticks;

        // command latch, idle only
        if (cur.state == ST_IDLE && cmd_t'(command) != CMD_NONE) begin
            nxt.bit_count   = '0;
            nxt.phase_count = '0;
            case (cmd_t'(command))
                CMD_START: nxt.state = ST_START;
                CMD_STOP:  nxt.state = ST_STOP;
                CMD_WRITE: begin
                    nxt.state      = ST_WRITE;
                    nxt.shift_byte = write_data;
                end
                CMD_WACK:  nxt.state = ST_WACK;
                CMD_READ: begin
                    nxt.state      = ST_READ;
                    nxt.shift_byte = '0;
                    nxt.held_ack   = ack_after_read;
                end
                CMD_ACK: begin
                    nxt.state    = ST_ACK;
                    nxt.held_ack = 1'b1;
                end
                default: begin
                    nxt.state    = ST_ACK;
                    nxt.held_ack = 1'b0;
                end
            endcase
        end

        if (nxt.state != ST_IDLE) begin
            // phase start: set pins
            if (nxt.phase_count == '0) begin
                unique case (nxt.state)
                    ST_START: begin
                        if (nxt.bit_count == 4'd0) begin
                            nxt.sda = 1'b1;
                            nxt.scl = 1'b1;
                        end else if (nxt.bit_count == 4'd1) begin
                            nxt.sda = 1'b0;
                        end else begin
                            nxt.scl = 1'b0;
                        end
                    end
                    ST_STOP: begin
                        if (nxt.bit_count == 4'd0)      nxt.sda = 1'b0;
                        else if (nxt.bit_count == 4'd1) nxt.scl = 1'b1;
                        else                            nxt.sda = 1'b1;
                    end
                    ST_WACK: begin
                        if (nxt.bit_count == 4'd0)      nxt.sda = 1'b1;
                        else if (nxt.bit_count == 4'd1) nxt.scl = 1'b1;
                        else                            nxt.scl = 1'b0;
                    end
                    ST_WRITE: begin
                        if (!nxt.bit_count[0]) begin
                            if (nxt.bit_count != 4'd0) nxt.scl = 1'b0;
                            nxt.sda = nxt.shift_byte[BYTE_W-1];
                        end else begin
                            nxt.scl = 1'b1;
                        end
                    end
                    ST_WREL: begin
                        nxt.scl = 1'b0;
                        nxt.sda = 1'b1;
                    end
                    ST_READ: begin
                        if (!nxt.bit_count[0]) begin
                            if (nxt.bit_count == 4'd0) nxt.sda = 1'b1;
                            nxt.scl = 1'b1;
                        end else begin
                            nxt.scl = 1'b0;
                        end
                    end
                    ST_ACK: begin
                        if (nxt.bit_count == 4'd0)      nxt.scl = 1'b0;
                        else if (nxt.bit_count == 4'd1) nxt.sda = ~nxt.held_ack;
                        else if (nxt.bit_count == 4'd2) nxt.scl = 1'b1;
                        else if (nxt.bit_count == 4'd3) nxt.scl = 1'b0;
                        else                            nxt.sda = 1'b1;
                    end
                    default: ;
                endcase
                nxt.phase_count = plen;
            end

            nxt.phase_count = nxt.phase_count - 8'd1;

            // phase end: sample and advance
            if (nxt.phase_count == '0) begin
                unique case (nxt.state)
                    ST_START, ST_STOP: begin
                        if (nxt.bit_count >= 4'd2) fin = 1'b1;
                        else nxt.bit_count = nxt.bit_count + 4'd1;
                    end
                    ST_WACK: begin
                        if (nxt.bit_count == 4'd1) begin
                            if (sda_in) begin
                                // nack: flag it and run a stop
                                nxt.nack      = 1'b1;
                                nxt.state     = ST_STOP;
                                nxt.bit_count = '0;
                            end else begin
                                nxt.nack      = 1'b0;
                                nxt.bit_count = 4'd2;
                            end
                        end else if (nxt.bit_count >= 4'd2) begin
                            fin = 1'b1;
                        end else begin
                            nxt.bit_count = nxt.bit_count + 4'd1;
                        end
                    end
                    ST_WRITE: begin
                        if (nxt.bit_count[0])
                            nxt.shift_byte = {nxt.shift_byte[BYTE_W-2:0], 1'b0};
                        if (nxt.bit_count == 4'd15) begin
                            nxt.state     = ST_WREL;
                            nxt.bit_count = '0;
                        end else begin
                            nxt.bit_count = nxt.bit_count + 4'd1;
                        end
                    end
                    ST_WREL: fin = 1'b1;
                    ST_READ: begin
                        if (!nxt.bit_count[0])
                            nxt.shift_byte = {nxt.shift_byte[BYTE_W-2:0], sda_in};
                        if (nxt.bit_count == 4'd15) begin
                            nxt.read_data = nxt.shift_byte;
                            nxt.state     = ST_ACK;
                            nxt.bit_count = '0;
                        end else begin
                            nxt.bit_count = nxt.bit_count + 4'd1;
                        end
                    end
                    ST_ACK: begin
                        if (nxt.bit_count >= 4'd4) fin = 1'b1;
                        else nxt.bit_count = nxt.bit_count + 4'd1;
                    end
                    default: fin = 1'b1;
                endcase
                if (fin) begin
                    nxt.state     = ST_IDLE;
                    nxt.bit_count = '0;
                    done          = 1'b1;
                end
            end
        end
    end

endmodule

>>> sv/i2c_master_bit_sequencer.sv
// Tick-level I2C master: drives SCL/SDA levels one tick per input transaction.
// Depends on i2cbs_pkg and i2cbs_core.
//
// Usage:
//   Slave stream (s_*): one transaction per bus tick. tdata carries the
//   command (ignored unless the sequencer is idle), the byte to write, the
//   ack choice for a read, and the sampled SDA level.
//   Master stream (m_*): exactly one transaction per input transaction, with
//   the pin levels, busy/done, the last read byte and the nack flag after
//   that tick.
//   APB port: register 0 (addr 0x0) is phase_ticks, the length of each pin
//   phase in ticks (0 behaves as 1). Write only while idle.
// A result is registered and valid in the cycle after its input is accepted.
// Throughput: one transaction per clock when not stalled; the state is one
//   register stage fed by single-pass logic, so ticks may arrive back to back.
// Stall: s_tready drops only when the result register is full and m_tready
//   is low; no tick is lost or duplicated.
// Reset (aresetn low, synchronous): idle, SCL and SDA released high,
//   nack flag and read byte cleared, phase_ticks = 2, result register empty.
module i2c_master_bit_sequencer (
    input  logic                                aclk,
    input  logic                                aresetn,
    // s_tdata: [2:0] command, [10:3] write_data, [11] ack_after_read,
    //          [12] sda_in, [15:13] zero
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [i2cbs_pkg::S_TDATA_W-1:0]     s_tdata,
    // m_tdata: [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
    //          [11:4] read_data, [12] nack_seen, [15:13] zero
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [i2cbs_pkg::M_TDATA_W-1:0]     m_tdata,
    // APB configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [i2cbs_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [i2cbs_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [i2cbs_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                pready
);
    import i2cbs_pkg::*;

    seq_t              seq_reg;
    seq_t              seq_next;
    logic              done_next;
    logic [BYTE_W-1:0] phase_ticks_reg;
    logic              m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic              s_accept;

    // Result register frees up when empty or being drained this cycle.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PHASE_TICKS)
                    ? {{(APB_DATA_W-BYTE_W){1'b0}}, phase_ticks_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= PHASE_TICKS_RST;
        end else if (psel && penable && pwrite && pready
                     && paddr == ADDR_PHASE_TICKS) begin
            phase_ticks_reg <= pwdata[BYTE_W-1:0];
        end
    end

    i2cbs_core u_core (
        .cur            (seq_reg),
        .command        (s_tdata[2:0]),
        .write_data     (s_tdata[10:3]),
        .ack_after_read (s_tdata[11]),
        .sda_in         (s_tdata[12]),
        .phase_ticks    (phase_ticks_reg),
        .nxt            (seq_next),
        .done           (done_next)
    );

    // Sequencer state advances only on an accepted tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seq_reg <= SEQ_RST;
        end else if (s_accept) begin
            seq_reg <= seq_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_accept) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= {3'b000,
                            seq_next.nack,
                            seq_next.read_data,
                            done_next,
                            (seq_next.state != ST_IDLE),
                            seq_next.sda,
                            seq_next.scl};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

>>> sv/i2cbs_checker.sv
// i2cbs_checker: port-level assertions for the I2C master bit sequencer.
// Depends on i2c_master_bit_sequencer ports; bound to it below.
module i2cbs_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    // Result register empties on reset.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Input side must be open whenever the result slot is free or draining.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid || m_tready) |-> s_tready)
        else $error("s_tready low with free result slot");

    // Every accepted tick yields a result next cycle.
    a_one_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted tick produced no result");

    // A completing tick never reports busy.
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[3]) |-> !m_tdata[2])
        else $error("done and busy together");

    // Stalled result holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind i2c_master_bit_sequencer i2cbs_checker u_i2cbs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/i2c_master_bit_sequencer_tb.sv
// Self-checking bench for i2c_master_bit_sequencer: streams bus ticks, predicts every
// result tick with a cycle-exact model of the SCL/SDA phase sequencer and checks it.
// Depends on i2cbs_pkg and the i2c_master_bit_sequencer RTL.
module i2c_master_bit_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2cbs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400_000;

    // one input transaction (one bus tick), laid out exactly as s_tdata[12:0]
    typedef struct packed {
        logic       sda;
        logic       ack;
        logic [7:0] wdata;
        cmd_t       cmd;
    } bus_tick_t;

    // one result transaction, laid out exactly as m_tdata[12:0]
    typedef struct packed {
        logic       nack;
        logic [7:0] rd;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } pins_t;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} stall_mode_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr  = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic        pready;

    i2c_master_bit_sequencer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Sequencer model state (mirrors the block's registers after each tick)
    // ---------------------------------------------------------------------
    state_t      seq_state  = ST_IDLE;
    logic [7:0]  ph_cnt     = '0;
    logic [3:0]  bit_cnt    = '0;
    logic [7:0]  shreg      = '0;
    logic        hold_ack   = 1'b0;
    logic        scl_q      = 1'b1;
    logic        sda_q      = 1'b1;
    logic        nack_q     = 1'b0;
    logic [7:0]  rd_byte    = '0;
    logic [7:0]  cfg_ticks  = PHASE_TICKS_RST;

    bus_tick_t   tick_backlog[$];   // ticks waiting for the driver
    pins_t       expected_pins[$];  // predicted results, oldest first
    stall_mode_t idle_mode = IDLE_NONE;

    int unsigned errors = 0;
    int unsigned queued = 0;
    int unsigned ticks_sent = 0;
    int unsigned results_checked = 0;
    int unsigned cmds_taken = 0;
    int unsigned nack_stops = 0;
    int unsigned bytes_read = 0;
    int unsigned cycles = 0;

    // Advance the model by one bus tick and return the pin/status levels after it.
    function automatic pins_t sequencer_tick(input bus_tick_t t);
        logic [7:0] plen;
        logic       fin;
        pins_t      o;
        plen = (cfg_ticks == 8'd0) ? 8'd1 : cfg_ticks;  // zero length acts as one tick
        fin  = 1'b0;

        // commands only land while idle; anything else is dropped
        if (seq_state == ST_IDLE && t.cmd != CMD_NONE) begin
            cmds_taken++;
            bit_cnt = '0;
            ph_cnt  = '0;
            case (t.cmd)
                CMD_START: seq_state = ST_START;
                CMD_STOP:  seq_state = ST_STOP;
                CMD_WRITE: begin seq_state = ST_WRITE; shreg = t.wdata; end
                CMD_WACK:  seq_state = ST_WACK;
                CMD_READ:  begin seq_state = ST_READ; shreg = '0; hold_ack = t.ack; end
                CMD_ACK:   begin seq_state = ST_ACK; hold_ack = 1'b1; end
                default:   begin seq_state = ST_ACK; hold_ack = 1'b0; end
            endcase
        end

        if (seq_state != ST_IDLE) begin
            // first tick of a phase: set the pins for that phase
            if (ph_cnt == 8'd0) begin
                case (seq_state)
                    ST_START: begin
                        if (bit_cnt == 0) begin sda_q = 1'b1; scl_q = 1'b1; end
                        else if (bit_cnt == 1) sda_q = 1'b0;
                        else scl_q = 1'b0;
                    end
                    ST_STOP: begin
                        if (bit_cnt == 0) sda_q = 1'b0;
                        else if (bit_cnt == 1) scl_q = 1'b1;
                        else sda_q = 1'b1;
                    end
                    ST_WACK: begin
                        if (bit_cnt == 0) sda_q = 1'b1;
                        else if (bit_cnt == 1) scl_q = 1'b1;
                        else scl_q = 1'b0;
                    end
                    ST_WRITE: begin
                        if (!bit_cnt[0]) begin
                            if (bit_cnt != 0) scl_q = 1'b0;
                            sda_q = shreg[7];
                        end else begin
                            scl_q = 1'b1;
                        end
                    end
                    ST_WREL: begin scl_q = 1'b0; sda_q = 1'b1; end
                    ST_READ: begin
                        if (!bit_cnt[0]) begin
                            if (bit_cnt == 0) sda_q = 1'b1;  // release SDA for the slave
                            scl_q = 1'b1;
                        end else begin
                            scl_q = 1'b0;
                        end
                    end
                    ST_ACK: begin
                        if (bit_cnt == 0) scl_q = 1'b0;
                        else if (bit_cnt == 1) sda_q = !hold_ack;
                        else if (bit_cnt == 2) scl_q = 1'b1;
                        else if (bit_cnt == 3) scl_q = 1'b0;
                        else sda_q = 1'b1;
                    end
                    default: ;
                endcase
                ph_cnt = plen;
            end
            ph_cnt = ph_cnt - 8'd1;

            // last tick of a phase: sample and step to the next phase
            if (ph_cnt == 8'd0) begin
                case (seq_state)
                    ST_START, ST_STOP: begin
                        if (bit_cnt >= 2) fin = 1'b1;
                        else bit_cnt++;
                    end
                    ST_WACK: begin
                        if (bit_cnt == 1) begin
                            if (t.sda) begin
                                // slave nacked: flag it and run a stop on our own
                                nack_q    = 1'b1;
                                seq_state = ST_STOP;
                                bit_cnt   = '0;
                                nack_stops++;
                            end else begin
                                nack_q  = 1'b0;
                                bit_cnt = 4'd2;
                            end
                        end else if (bit_cnt >= 2) begin
                            fin = 1'b1;
                        end else begin
                            bit_cnt++;
                        end
                    end
                    ST_WRITE: begin
                        if (bit_cnt[0]) shreg = shreg << 1;
                        if (bit_cnt == 4'd15) begin
                            seq_state = ST_WREL;
                            bit_cnt   = '0;
                        end else begin
                            bit_cnt++;
                        end
                    end
                    ST_WREL: fin = 1'b1;
                    ST_READ: begin
                        if (!bit_cnt[0]) shreg = {shreg[6:0], t.sda};
                        if (bit_cnt == 4'd15) begin
                            rd_byte   = shreg;
                            seq_state = ST_ACK;
                            bit_cnt   = '0;
                            bytes_read++;
                        end else begin
                            bit_cnt++;
                        end
                    end
                    ST_ACK: begin
                        if (bit_cnt >= 4) fin = 1'b1;
                        else bit_cnt++;
                    end
                    default: fin = 1'b1;
                endcase
                if (fin) begin
                    seq_state = ST_IDLE;
                    bit_cnt   = '0;
                end
            end
        end

        o.scl  = scl_q;
        o.sda  = sda_q;
        o.busy = (seq_state != ST_IDLE);
        o.done = fin;
        o.rd   = rd_byte;
        o.nack = nack_q;
        return o;
    endfunction

    // ---------------------------------------------------------------------
    // Driver: feeds tick_backlog onto the slave stream, predicting each
    // transaction at the edge it is accepted.
    // ---------------------------------------------------------------------
    bus_tick_t drv_tick;

    always @(posedge aclk) begin
        logic gap;
        gap = (idle_mode == IDLE_SEND && $urandom_range(99) < 60) ||
              (idle_mode == IDLE_BOTH && $urandom_range(99) < 16);
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_pins.push_back(sequencer_tick(drv_tick));
                ticks_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (tick_backlog.size() != 0 && !gap) begin
                    drv_tick = tick_backlog.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {3'b000, drv_tick};
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            case (idle_mode)
                IDLE_RECV: m_tready <= ($urandom_range(99) >= 60);
                IDLE_BOTH: m_tready <= ($urandom_range(99) >= 16);
                default:   m_tready <= 1'b1;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: each result transaction against the oldest prediction
    // ---------------------------------------------------------------------
    task automatic flag_field(input string f, input int unsigned want, input int unsigned got);
        errors++;
        $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, f, want, got);
    endtask

    always @(posedge aclk) begin
        pins_t want;
        pins_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = pins_t'(m_tdata[12:0]);
            if (expected_pins.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none actual %h",
                         $time, m_tdata);
            end else begin
                want = expected_pins.pop_front();
                results_checked++;
                if (got.scl  !== want.scl)  flag_field("scl_level", want.scl, got.scl);
                if (got.sda  !== want.sda)  flag_field("sda_level", want.sda, got.sda);
                if (got.busy !== want.busy) flag_field("busy_res", want.busy, got.busy);
                if (got.done !== want.done) flag_field("done_res", want.done, got.done);
                if (got.rd   !== want.rd)   flag_field("read_data", want.rd, got.rd);
                if (got.nack !== want.nack) flag_field("nack_seen", want.nack, got.nack);
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, expected_pins.size());
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------

    // Queue a command tick and enough filler ticks to cover its run, so the
    // next command lands on the first idle tick. Filler carries random
    // commands that the busy block must ignore. SDA is held at lvl for the
    // whole command when hold is set (always for wait-ack).
    task automatic push_cmd(input cmd_t c, input logic [7:0] wd, input logic ak,
                            input logic lvl, input bit hold);
        int unsigned phases;
        int unsigned span;
        bit          fixed;
        bus_tick_t   t;
        fixed = hold || (c == CMD_WACK);
        case (c)
            CMD_NONE:            phases = 0;
            CMD_START, CMD_STOP: phases = 3;
            CMD_WRITE:           phases = 17;
            CMD_WACK:            phases = lvl ? 5 : 3;   // nack adds the automatic stop
            CMD_READ:            phases = 21;
            default:             phases = 5;
        endcase
        span = phases * ((cfg_ticks == 8'd0) ? 1 : cfg_ticks);
        t.cmd   = c;
        t.wdata = wd;
        t.ack   = ak;
        t.sda   = fixed ? lvl : 1'($urandom);
        tick_backlog.push_back(t);
        queued++;
        for (int i = 1; i < span; i++) begin
            t.cmd   = ($urandom_range(3) == 0) ? cmd_t'($urandom_range(1, 7)) : CMD_NONE;
            t.wdata = 8'($urandom);
            t.ack   = 1'($urandom);
            t.sda   = fixed ? lvl : 1'($urandom);
            tick_backlog.push_back(t);
            queued++;
        end
        // occasional quiet ticks between commands
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                t.cmd   = CMD_NONE;
                t.wdata = 8'($urandom);
                t.ack   = 1'($urandom);
                t.sda   = 1'($urandom);
                tick_backlog.push_back(t);
                queued++;
            end
        end
    endtask

    // Mostly well-formed I2C transfers (start, bytes, stop) with random
    // content; the rest are lone commands in arbitrary order.
    task automatic run_traffic(input int unsigned budget);
        int unsigned first;
        int unsigned nbytes;
        bit          nacked;
        cmd_t        c;
        first = queued;
        while (queued - first < budget) begin
            if ($urandom_range(99) < 80) begin
                push_cmd(CMD_START, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
                nbytes = $urandom_range(1, 3);
                nacked = 0;
                for (int k = 0; k < nbytes && !nacked; k++) begin
                    if ($urandom_range(1) == 0) begin
                        push_cmd(CMD_WRITE, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
                        nacked = ($urandom_range(4) == 0);
                        push_cmd(CMD_WACK, 8'($urandom), 1'($urandom), nacked, 1'b1);
                    end else begin
                        push_cmd(CMD_READ, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
                    end
                end
                // a nacked write already ended with the block's own stop
                if (!nacked) begin
                    if ($urandom_range(5) == 0)
                        push_cmd($urandom_range(1) ? CMD_ACK : CMD_NACK,
                                 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
                    push_cmd(CMD_STOP, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
                end
            end else begin
                c = cmd_t'($urandom_range(1, 7));
                push_cmd(c, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
            end
        end
    endtask

    // Wait until every queued tick has been taken and every result checked.
    task automatic wait_quiet();
        while (tick_backlog.size() != 0 || s_tvalid || expected_pins.size() != 0)
            @(negedge aclk);
    endtask

    // Bring the sequencer itself to idle before touching the register.
    task automatic settle_idle();
        wait_quiet();
        while (seq_state != ST_IDLE) begin
            repeat (8) push_cmd(CMD_NONE, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
            wait_quiet();
        end
        repeat (3) @(posedge aclk);
    endtask

    // APB write of phase_ticks followed by a read-back check
    task automatic set_phase_ticks(input logic [7:0] v);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_PHASE_TICKS;
        pwdata  <= {24'd0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);        // register written at this edge
        cfg_ticks = v;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {24'd0, v}) begin
            errors++;
            $display("%0t ns: phase_ticks read-back mismatch, expected %0h actual %0h",
                     $time, {24'd0, v}, prdata);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial begin
        int plan [8];
        plan = '{1, 0, 3, 9, 2, 4, 1, 0};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed pass at the reset phase length: byte extremes, ack and
        // nack on wait-ack (nack triggers the automatic stop), reads ending
        // in ack and in nack, standalone ack/nack and stop.
        push_cmd(CMD_START, 8'h00, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_WRITE, 8'hFF, 1'b0, 1'b0, 1'b0);
        push_cmd(CMD_WACK,  8'h00, 1'b0, 1'b0, 1'b1);
        push_cmd(CMD_WRITE, 8'h00, 1'b1, 1'b1, 1'b0);
        push_cmd(CMD_WACK,  8'hFF, 1'b1, 1'b1, 1'b1);
        push_cmd(CMD_START, 8'hFF, 1'b1, 1'b0, 1'b0);
        push_cmd(CMD_WRITE, 8'hA5, 1'b0, 1'b0, 1'b0);
        push_cmd(CMD_WACK,  8'h5A, 1'b0, 1'b0, 1'b1);   // ack clears the nack flag
        push_cmd(CMD_READ,  8'h00, 1'b1, 1'b1, 1'b1);   // all-ones byte, ack after
        push_cmd(CMD_READ,  8'hFF, 1'b0, 1'b0, 1'b1);   // all-zeros byte, nack after
        push_cmd(CMD_READ,  8'h3C, 1'b1, 1'b0, 1'b0);
        push_cmd(CMD_ACK,   8'h00, 1'b0, 1'b0, 1'b0);
        push_cmd(CMD_NACK,  8'hFF, 1'b1, 1'b1, 1'b0);
        push_cmd(CMD_STOP,  8'h00, 1'b0, 1'b1, 1'b0);
        push_cmd(CMD_NONE,  8'hFF, 1'b1, 1'b0, 1'b0);
        settle_idle();

        // Random phases over several phase lengths (0 acts as 1) and all
        // stall patterns; the longest length only runs a short transfer.
        foreach (plan[i]) begin
            set_phase_ticks(plan[i][7:0]);
            idle_mode = stall_mode_t'(i % 4);
            if (plan[i] == 9) begin
                push_cmd(CMD_START, 8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
                push_cmd(CMD_WACK,  8'($urandom), 1'($urandom), 1'b0, 1'b1);
                push_cmd(CMD_NACK,  8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
                push_cmd(CMD_STOP,  8'($urandom), 1'($urandom), 1'($urandom), 1'b0);
            end else begin
                run_traffic(100);
            end
            settle_idle();
        end

        wait_quiet();
        repeat (4) @(posedge aclk);
        if (expected_pins.size() != 0) begin
            errors++;
            $display("%0t ns: %0d predicted results never arrived",
                     $time, expected_pins.size());
        end

        $display("Sent %0d bus ticks over %0d configuration passes, %0d results checked",
                 ticks_sent, $size(plan) + 1, results_checked);
        $display("%0d commands taken, %0d bytes read, %0d nack-triggered stops, %0d errors",
                 cmds_taken, bytes_read, nack_stops, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> i2c_master_bit_sequencer.f
sv/i2cbs_pkg.sv
sv/i2cbs_core.sv
sv/i2c_master_bit_sequencer.sv
sv/i2cbs_checker.sv
sim/i2c_master_bit_sequencer_tb.sv
